// ===== rtl/torque_magnitude_and_slew_limiter_core_defines.svh =====
// assertion macros shared by the torque limiter rtl
`ifndef TORQUE_MAGNITUDE_AND_SLEW_LIMITER_CORE_DEFINES_SVH
`define TORQUE_MAGNITUDE_AND_SLEW_LIMITER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TMSL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define TMSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tmsl_pkg.sv =====
// package: constants and codes of the torque limiter
`timescale 1ns / 1ps
package tmsl_pkg;

	localparam int TORQUE_WIDTH_DEF = 32;
	localparam int TIME_WIDTH_DEF   = 48;

	localparam int MAX_TORQUE_W = 31;
	localparam int MAX_SLEW_W   = 32;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_INDEX_W  = 1;

	localparam logic [MAX_TORQUE_W-1:0] MAX_TORQUE_RST = 31'd655360;
	localparam logic [MAX_SLEW_W-1:0]   MAX_SLEW_RST   = 32'd65536;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MAX_TORQUE = 1'b0,
		CFG_MAX_SLEW   = 1'b1
	} cfg_idx_t;

	localparam logic MODE_APPLY = 1'b0;
	localparam logic MODE_RESET = 1'b1;

endpackage

// ===== rtl/tmsl_if.sv =====
// interfaces: command and result channels of the torque limiter
`timescale 1ns / 1ps
interface tmsl_cmd_if #(
	parameter int TORQUE_WIDTH = tmsl_pkg::TORQUE_WIDTH_DEF,
	parameter int TIME_WIDTH   = tmsl_pkg::TIME_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic signed [TORQUE_WIDTH-1:0] torque_in;
	logic        [TIME_WIDTH-1:0]   time_stamp;

	modport source (output valid, output mode, output torque_in, output time_stamp,
		input ready);
	modport sink (input valid, input mode, input torque_in, input time_stamp,
		output ready);
endinterface

interface tmsl_rsp_if #(
	parameter int TORQUE_WIDTH = tmsl_pkg::TORQUE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [TORQUE_WIDTH-1:0] magnitude_limited;
	logic signed [TORQUE_WIDTH-1:0] torque_out;
	logic                           saturated;
	logic                           slew_hit;

	modport source (output valid, output magnitude_limited, output torque_out,
		output saturated, output slew_hit, input ready);
	modport sink (input valid, input magnitude_limited, input torque_out,
		input saturated, input slew_hit, output ready);
endinterface

// ===== rtl/tmsl_step_limit.sv =====
// step limit: saturated product of slew rate and elapsed ticks
`timescale 1ns / 1ps
module tmsl_step_limit #(
	parameter int TORQUE_WIDTH = tmsl_pkg::TORQUE_WIDTH_DEF,
	parameter int DT_WIDTH     = TORQUE_WIDTH + 1
) (
	input  logic [DT_WIDTH-1:0]             dt,
	input  logic                            dt_big,
	input  logic [tmsl_pkg::MAX_SLEW_W-1:0] slew,
	output logic [TORQUE_WIDTH+1:0]         lim
);
	localparam int SW = tmsl_pkg::MAX_SLEW_W;
	localparam int PW = DT_WIDTH + SW;
	localparam int LW = TORQUE_WIDTH + 2;

	logic [PW-1:0] prod;
	logic          over;
	logic [LW-1:0] cap;

	assign prod = {{SW{1'b0}}, dt} * {{DT_WIDTH{1'b0}}, slew};
	// anything at or past the cap bit means the product reached the cap
	assign over = |prod[PW-1:TORQUE_WIDTH+1];
	assign cap  = {1'b1, {(TORQUE_WIDTH+1){1'b0}}};

	always_comb begin
		if (slew == '0) begin
			lim = '0;
		end else if (dt_big || over) begin
			lim = cap;
		end else begin
			lim = {1'b0, prod[TORQUE_WIDTH:0]};
		end
	end
endmodule

// ===== rtl/torque_magnitude_and_slew_limiter_core.sv =====
// top level: torque magnitude clamp and slew limiter, four-stage pipeline
//
//  channel | dir | handshake     | payload
//  cmd     | in  | valid / ready | mode, torque_in, time_stamp
//  rsp     | out | valid / ready | magnitude_limited, torque_out, saturated, slew_hit
//  cfg     | in  | cfg_we        | cfg_index, cfg_data
//
// one beat accepted per cycle while not stalled; a result is offered from the result register
// stages: capture, magnitude clamp and tick delta, slew multiplier, slew clamp
// a reset-mode beat flows through in order and yields no result beat
// stages hold while the result register waits; empty stages still fill
// arst_n clears valid bits, the time history and the previous output, and loads config defaults
`timescale 1ns / 1ps
`include "torque_magnitude_and_slew_limiter_core_defines.svh"
module torque_magnitude_and_slew_limiter_core #(
	parameter int TORQUE_WIDTH = tmsl_pkg::TORQUE_WIDTH_DEF,
	parameter int TIME_WIDTH   = tmsl_pkg::TIME_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tmsl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tmsl_pkg::CFG_DATA_W-1:0]  cfg_data,
	tmsl_cmd_if.sink                         cmd,
	tmsl_rsp_if.source                       rsp
);
	localparam int TW  = TORQUE_WIDTH;
	localparam int TMW = TIME_WIDTH;
	localparam int MTW = tmsl_pkg::MAX_TORQUE_W;
	localparam int SW  = tmsl_pkg::MAX_SLEW_W;
	localparam int CW  = ((TW > MTW) ? TW : MTW) + 2;
	localparam int DW  = TW + 1;
	localparam int EW  = ((TMW > DW) ? TMW : DW) + 1;
	localparam int LW  = TW + 2;
	localparam int FW  = TW + 3;

	// configuration
	logic [MTW-1:0] max_torque_q;
	logic [SW-1:0]  max_slew_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_torque_q <= tmsl_pkg::MAX_TORQUE_RST;
			max_slew_q   <= tmsl_pkg::MAX_SLEW_RST;
		end else if (cfg_we) begin
			unique case (tmsl_pkg::cfg_idx_t'(cfg_index))
				tmsl_pkg::CFG_MAX_TORQUE: max_torque_q <= cfg_data[MTW-1:0];
				tmsl_pkg::CFG_MAX_SLEW:   max_slew_q   <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic v_s1, v_s2, v_s3, out_vld_q;
	logic rdy1, rdy2, rdy3, out_free, fire3;
	logic cmd_fire;
	logic mode_s1, mode_s2, mode_s3;

	assign out_free = !out_vld_q || rsp.ready;
	assign fire3    = v_s3 && (out_free || (mode_s3 == tmsl_pkg::MODE_RESET));
	assign rdy3     = !v_s3 || fire3;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign cmd.ready = rdy1;
	assign cmd_fire  = cmd.valid && rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= cmd.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (fire3 && (mode_s3 == tmsl_pkg::MODE_APPLY)) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// time history, follows the accepted command order
	logic [TMW-1:0] prev_time_q;
	logic           time_known_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q  <= '0;
			time_known_q <= 1'b0;
		end else if (cmd_fire) begin
			if (cmd.mode == tmsl_pkg::MODE_RESET) begin
				prev_time_q  <= '0;
				time_known_q <= 1'b0;
			end else begin
				prev_time_q  <= cmd.time_stamp;
				time_known_q <= 1'b1;
			end
		end
	end

	// stage 1: capture
	logic signed [TW-1:0] tq_s1;
	logic [TMW-1:0]       now_s1, pt_s1;
	logic                 tk_s1;

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			mode_s1 <= cmd.mode;
			tq_s1   <= cmd.torque_in;
			now_s1  <= cmd.time_stamp;
			pt_s1   <= prev_time_q;
			tk_s1   <= time_known_q;
		end
	end

	// stage 2: magnitude clamp and tick delta
	logic signed [CW-1:0] req_x, lim_x, neg_x, mag_x;
	logic [TMW:0]         diff;
	logic [TMW-1:0]       dt_full;
	logic [EW-1:0]        dt_ext;

	always_comb begin
		req_x = {{(CW-TW){tq_s1[TW-1]}}, tq_s1};
		lim_x = {{(CW-MTW){1'b0}}, max_torque_q};
		neg_x = -lim_x;
		if (req_x > lim_x) begin
			mag_x = lim_x;
		end else if (req_x < neg_x) begin
			mag_x = neg_x;
		end else begin
			mag_x = req_x;
		end
	end

	assign diff    = {1'b0, now_s1} - {1'b0, pt_s1};
	// a borrow means time went backwards
	assign dt_full = (tk_s1 && !diff[TMW]) ? diff[TMW-1:0] : '0;
	assign dt_ext  = {{(EW-TMW){1'b0}}, dt_full};

	logic signed [TW-1:0] mag_s2;
	logic                 sat_s2, tk_s2, dtbig_s2;
	logic [DW-1:0]        dt_s2;

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			mode_s2  <= mode_s1;
			mag_s2   <= mag_x[TW-1:0];
			sat_s2   <= (mag_x != req_x);
			tk_s2    <= tk_s1;
			dt_s2    <= dt_ext[DW-1:0];
			dtbig_s2 <= |dt_ext[EW-1:DW];
		end
	end

	// stage 3: allowed step
	logic [LW-1:0] lim_c;

	tmsl_step_limit #(
		.TORQUE_WIDTH(TW),
		.DT_WIDTH    (DW)
	) u_step_limit (
		.dt    (dt_s2),
		.dt_big(dtbig_s2),
		.slew  (max_slew_q),
		.lim   (lim_c)
	);

	logic signed [TW-1:0] mag_s3;
	logic                 sat_s3, tk_s3;
	logic [LW-1:0]        lim_s3;

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			mode_s3 <= mode_s2;
			mag_s3  <= mag_s2;
			sat_s3  <= sat_s2;
			tk_s3   <= tk_s2;
			lim_s3  <= lim_c;
		end
	end

	// stage 4: clamp to prev +/- step once time is known; prev output takes the result, or the magnitude on reset
	logic signed [TW-1:0] prev_out_q;
	logic signed [FW-1:0] prev_x, step_x, mag3_x, hi_x, lo_x, res_x;

	always_comb begin
		prev_x = {{3{prev_out_q[TW-1]}}, prev_out_q};
		step_x = {1'b0, lim_s3};
		mag3_x = {{3{mag_s3[TW-1]}}, mag_s3};
		hi_x   = prev_x + step_x;
		lo_x   = prev_x - step_x;
		if (!tk_s3) begin
			res_x = mag3_x;
		end else if (mag3_x > hi_x) begin
			res_x = hi_x;
		end else if (mag3_x < lo_x) begin
			res_x = lo_x;
		end else begin
			res_x = mag3_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_out_q <= '0;
		end else if (fire3) begin
			if (mode_s3 == tmsl_pkg::MODE_RESET) begin
				prev_out_q <= mag_s3;
			end else begin
				prev_out_q <= res_x[TW-1:0];
			end
		end
	end

	// result register
	logic signed [TW-1:0] mag_q, tq_out_q;
	logic                 sat_q, rate_q;

	always_ff @(posedge clk) begin
		if (fire3 && (mode_s3 == tmsl_pkg::MODE_APPLY)) begin
			mag_q    <= mag_s3;
			tq_out_q <= res_x[TW-1:0];
			sat_q    <= sat_s3;
			rate_q   <= (res_x != mag3_x);
		end
	end

	assign rsp.valid             = out_vld_q;
	assign rsp.magnitude_limited = mag_q;
	assign rsp.torque_out        = tq_out_q;
	assign rsp.saturated         = sat_q;
	assign rsp.slew_hit          = rate_q;

	`TMSL_ASSERT_NOW(a_time_forget, $fell(time_known_q), $past(cmd.valid && cmd.ready && (cmd.mode == tmsl_pkg::MODE_RESET)), "time history dropped without a reset beat")
	`TMSL_ASSERT_NEXT(a_result_load, fire3 && (mode_s3 == tmsl_pkg::MODE_APPLY), out_vld_q && (tq_out_q == prev_out_q), "apply beat did not reach the result register")
	`TMSL_ASSERT_NOW(a_no_rate_first, out_vld_q && rate_q, tq_out_q != mag_q, "rate flag set with unchanged output")
	`TMSL_ASSERT_NEXT(a_hold_stall, out_vld_q && !rsp.ready, out_vld_q && $stable(tq_out_q), "result register changed while stalled")
endmodule
